FILE: rtl/stuffed_frame_parser_crc8_top_assert.svh
// Assertion macros shared by the frame parser modules.
`ifndef STUFFED_FRAME_PARSER_CRC8_TOP_ASSERT_SVH
`define STUFFED_FRAME_PARSER_CRC8_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

FILE: rtl/sfp_pkg.sv
// Shared types, constants and CRC function of the stuffed frame parser.
package sfp_pkg;

  localparam logic [7:0] SYNC_A    = 8'hAA;
  localparam logic [7:0] SYNC_B    = 8'h55;
  localparam logic [7:0] ESC_MARK  = 8'h7D;
  localparam logic [7:0] ESC_FLIP  = 8'h20;
  localparam logic [7:0] SYNC_PAIR = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'hE5;
  localparam logic [7:0] CRC_INIT  = 8'h00;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_CRC = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_BAD_ESC = 3'd3,
    ST_TRUNC   = 3'd4
  } fstat_t;

  typedef struct packed {
    fstat_t      frame_status;
    logic [7:0]  command;
    logic [5:0]  payload_count;
    logic [7:0]  payload_byte;
    logic        byte_present;
    logic        last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic   sync_load;   // wire byte becomes first sync byte
    logic   len_load;    // wire byte is the length: restart fill and crc
    logic   store;       // store (decoded) byte and update crc
    logic   flip;        // decode escaped byte
    logic   push;        // queue a single-item report
    fstat_t push_code;
    logic   emit_start;  // start the payload run
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sync;
    logic is_esc;
    logic esc_ok;
    logic pair_ok;
    logic len_bad;
    logic fill_done;
    logic crc_hit;
    logic crc_hit_esc;
    logic len_one;
    logic out_space;
    logic emit_busy;
  } sts_t;

  // reflected CRC-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/sfp_if.sv
// Valid/ready channel interfaces for wire bytes and frame reports.
interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;

  modport source (output valid, output wire_byte, input ready);
  modport sink   (input valid, input wire_byte, output ready);
endinterface

interface sfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_status;
  logic [7:0] command;
  logic [5:0] payload_count;
  logic [7:0] payload_byte;
  logic       byte_present;
  logic       last;

  modport source (output valid, output frame_status, output command, output payload_count,
                  output payload_byte, output byte_present, output last, input ready);
  modport sink   (input valid, input frame_status, input command, input payload_count,
                  input payload_byte, input byte_present, input last, output ready);
endinterface

FILE: rtl/sfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sfp_ctrl.sv
// Frame parser controller: parse phase state machine and run sequencing.
module sfp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfp_pkg::sts_t sts,
  output sfp_pkg::cmd_t cmd
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT, S_SYNC2, S_LEN, S_DATA, S_DATA_ESC, S_CRC, S_CRC_ESC, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   fire;

  assign in_ready = (state_r != S_EMIT) && sts.out_space;
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    if (state_r == S_EMIT) begin
      if (!sts.emit_busy) begin
        state_nxt = S_HUNT;
      end
    end else if (fire) begin
      unique case (state_r)
        S_SYNC2: begin
          if (sts.pair_ok) begin
            state_nxt = S_LEN;
          end else if (sts.is_sync) begin
            cmd.sync_load = 1'b1;
          end else begin
            state_nxt = S_HUNT;
          end
        end
        S_LEN: begin
          cmd.len_load = 1'b1;
          if (sts.len_bad) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_BAD_LEN;
            cmd.sync_load = sts.is_sync;
            state_nxt     = sts.is_sync ? S_SYNC2 : S_HUNT;
          end else begin
            cmd.store = 1'b1;
            state_nxt = S_DATA;
          end
        end
        S_DATA: begin
          if (sts.is_esc) begin
            state_nxt = S_DATA_ESC;
          end else if (sts.is_sync) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_TRUNC;
            cmd.sync_load = 1'b1;
            state_nxt     = S_SYNC2;
          end else begin
            cmd.store = 1'b1;
            state_nxt = sts.fill_done ? S_CRC : S_DATA;
          end
        end
        S_DATA_ESC: begin
          if (!sts.esc_ok) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_BAD_ESC;
            cmd.sync_load = sts.is_sync;
            state_nxt     = sts.is_sync ? S_SYNC2 : S_HUNT;
          end else begin
            cmd.store = 1'b1;
            cmd.flip  = 1'b1;
            state_nxt = sts.fill_done ? S_CRC : S_DATA;
          end
        end
        S_CRC, S_CRC_ESC: begin
          if (state_r == S_CRC && sts.is_esc) begin
            state_nxt = S_CRC_ESC;
          end else if ((state_r == S_CRC && sts.is_sync) ||
                       (state_r == S_CRC_ESC && !sts.esc_ok)) begin
            cmd.push      = 1'b1;
            cmd.push_code = (state_r == S_CRC) ? ST_TRUNC : ST_BAD_ESC;
            cmd.sync_load = sts.is_sync;
            state_nxt     = sts.is_sync ? S_SYNC2 : S_HUNT;
          end else begin
            state_nxt = S_HUNT;
            if ((state_r == S_CRC) ? sts.crc_hit : sts.crc_hit_esc) begin
              if (sts.len_one) begin
                cmd.push      = 1'b1;
                cmd.push_code = ST_OK;
              end else begin
                cmd.emit_start = 1'b1;
                state_nxt      = S_EMIT;
              end
            end else begin
              cmd.push      = 1'b1;
              cmd.push_code = ST_BAD_CRC;
            end
          end
        end
        default: begin
          // hunting
          cmd.sync_load = sts.is_sync;
          state_nxt     = sts.is_sync ? S_SYNC2 : S_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "stuffed_frame_parser_crc8_top_assert.svh"

  `SFP_ASSERT_NEXT(a_emit_enter, cmd.emit_start, state_r == S_EMIT)
  `SFP_ASSERT_IMPL(a_one_report, cmd.emit_start, !cmd.push && !cmd.store)
  `SFP_ASSERT_IMPL(a_hold_in_emit, state_r == S_EMIT, !in_ready)

endmodule

FILE: rtl/sfp_dp.sv
// Frame parser datapath: frame store, CRC, payload run and output queue.
module sfp_dp #(
  parameter int MAX_DATA = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    wire_byte,
  input  sfp_pkg::cmd_t cmd,
  output sfp_pkg::sts_t sts,
  input  logic          out_ready,
  output logic          out_valid,
  output sfp_pkg::out_t out_item
);
  import sfp_pkg::*;

  localparam int AW = $clog2(MAX_DATA);
  localparam int LW = $clog2(MAX_DATA);
  localparam int FW = $clog2(MAX_DATA + 1);

  logic [7:0]    first_sync_r;
  logic [LW-1:0] frame_length_r;
  logic [FW-1:0] fill_r, fill_base;
  logic [7:0]    crc_r, crc_base;
  logic [7:0]    cmd_byte_r;
  logic [7:0]    st_byte;

  // payload run
  logic [AW-1:0] emit_addr_r;
  logic [LW-1:0] emit_left_r;
  logic          inflight_r, inflight_last_r;
  logic          issue;
  logic [2:0]    occ;
  logic [7:0]    ram_rdata;

  // two-entry output queue
  out_t          slot_r [2];
  logic          rd_ptr_r, wr_ptr_r;
  logic [1:0]    cnt_r;
  logic          pop, push_any;
  out_t          push_item;

  assign st_byte   = cmd.flip ? (wire_byte ^ ESC_FLIP) : wire_byte;
  assign fill_base = cmd.len_load ? '0 : fill_r;
  assign crc_base  = cmd.len_load ? CRC_INIT : crc_r;

  assign sts.is_sync     = (wire_byte == SYNC_A) || (wire_byte == SYNC_B);
  assign sts.is_esc      = (wire_byte == ESC_MARK);
  assign sts.esc_ok      = (wire_byte == (SYNC_A ^ ESC_FLIP)) ||
                           (wire_byte == (SYNC_B ^ ESC_FLIP)) ||
                           (wire_byte == (ESC_MARK ^ ESC_FLIP));
  assign sts.pair_ok     = ((first_sync_r ^ wire_byte) == SYNC_PAIR);
  assign sts.len_bad     = (wire_byte == 8'd0) || ({1'b0, wire_byte} >= 9'(MAX_DATA));
  assign sts.fill_done   = (fill_r >= FW'(frame_length_r));
  assign sts.crc_hit     = (wire_byte == crc_r);
  assign sts.crc_hit_esc = ((wire_byte ^ ESC_FLIP) == crc_r);
  assign sts.len_one     = (frame_length_r == LW'(1));
  assign sts.out_space   = (cnt_r != 2'd2);
  assign sts.emit_busy   = (emit_left_r != '0) || inflight_r;

  sfp_ram #(.WIDTH(8), .DEPTH(MAX_DATA)) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (fill_base[AW-1:0]),
    .wdata (st_byte),
    .raddr (emit_addr_r),
    .rdata (ram_rdata)
  );

  assign pop   = out_valid && out_ready;
  // issue a read only if its data will find a queue slot
  assign occ   = {1'b0, cnt_r} - {2'b0, pop} + {2'b0, inflight_r};
  assign issue = (emit_left_r != '0) && (occ < 3'd2);

  always_comb begin
    push_any  = cmd.push || inflight_r;
    push_item = '0;
    if (inflight_r) begin
      push_item.frame_status  = ST_OK;
      push_item.command       = cmd_byte_r;
      push_item.payload_count = 6'(frame_length_r - LW'(1));
      push_item.payload_byte  = ram_rdata;
      push_item.byte_present  = 1'b1;
      push_item.last          = inflight_last_r;
    end else begin
      push_item.frame_status = cmd.push_code;
      push_item.command      = (cmd.push_code == ST_OK) ? cmd_byte_r : 8'd0;
      push_item.last         = 1'b1;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_any) begin
      slot_r[wr_ptr_r] <= push_item;
    end
    // command byte mirrors store entry one
    if (cmd.store && fill_base == FW'(1)) begin
      cmd_byte_r <= st_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r    <= 8'd0;
      frame_length_r  <= '0;
      fill_r          <= '0;
      crc_r           <= CRC_INIT;
      emit_addr_r     <= '0;
      emit_left_r     <= '0;
      inflight_r      <= 1'b0;
      inflight_last_r <= 1'b0;
      rd_ptr_r        <= 1'b0;
      wr_ptr_r        <= 1'b0;
      cnt_r           <= 2'd0;
    end else begin
      if (cmd.sync_load) begin
        first_sync_r <= wire_byte;
      end
      if (cmd.len_load) begin
        frame_length_r <= wire_byte[LW-1:0];
      end
      // a length byte that is stored restarts fill and crc through the bases
      if (cmd.store) begin
        fill_r <= fill_base + FW'(1);
        crc_r  <= crc8_step(crc_base, st_byte);
      end else if (cmd.len_load) begin
        fill_r <= '0;
        crc_r  <= CRC_INIT;
      end
      if (cmd.emit_start) begin
        emit_addr_r <= AW'(2);
        emit_left_r <= frame_length_r - LW'(1);
      end else if (issue) begin
        emit_addr_r <= emit_addr_r + AW'(1);
        emit_left_r <= emit_left_r - LW'(1);
      end
      inflight_r      <= issue;
      inflight_last_r <= issue && (emit_left_r == LW'(1));
      if (push_any) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push_any} - {1'b0, pop};
    end
  end

`include "stuffed_frame_parser_crc8_top_assert.svh"

  `SFP_ASSERT_IMPL(a_push_clash, inflight_r, !cmd.push)
  `SFP_ASSERT_IMPL(a_no_overflow, cnt_r == 2'd2 && push_any, pop)
  `SFP_ASSERT_NEXT(a_run_last, inflight_r && inflight_last_r, emit_left_r == '0)

endmodule

FILE: rtl/stuffed_frame_parser_crc8_top.sv
// Top level of the byte-stuffed frame parser with CRC-8 check.
// Usage:
//  - in_ch carries one raw wire byte per item (valid/ready). The parser hunts
//    for a sync pair (AA 55 or 55 AA), reads a length byte, that many
//    unescaped command/payload bytes and a CRC byte (reflected CRC-8, 0xE5).
//  - out_ch carries the frame report: one item per payload byte for a good
//    frame with payload (last on the final one), else one status item.
//  - Bytes are taken one per cycle while a frame is parsed and the output
//    queue has space. A single-item report lands in the output queue at the
//    edge that takes its last byte and is visible the next cycle.
//  - A good frame with payload runs L-1 items out of the frame store RAM
//    after the CRC byte, one per cycle while the sink keeps up; in_ch.ready
//    is low for the run, which goes through the single RAM read port.
//  - out_ch has a two-entry queue, so input keeps flowing while one report
//    waits; when the sink stalls with both entries full, in_ch.ready drops.
//  - Reset (rst_n low, synchronous) returns to hunting and empties the queue.
//    The frame store is not cleared; it needs no clearing pass.
module stuffed_frame_parser_crc8_top #(
  parameter int MAX_DATA = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  sfp_in_if.sink           in_ch,
  sfp_out_if.source        out_ch
);
  import sfp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  out_t out_item;
  logic out_valid;

  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfp_dp #(.MAX_DATA(MAX_DATA)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .wire_byte (in_ch.wire_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.frame_status  = out_item.frame_status;
  assign out_ch.command       = out_item.command;
  assign out_ch.payload_count = out_item.payload_count;
  assign out_ch.payload_byte  = out_item.payload_byte;
  assign out_ch.byte_present  = out_item.byte_present;
  assign out_ch.last          = out_item.last;

endmodule
